@@ rtl/uvp_pkg.sv @@
// ----------------------------------------------------------------------------
// uvp_pkg
// Shared types and constants for the UYVY to v210 packer.
// ----------------------------------------------------------------------------
`default_nettype none

package uvp_pkg;

    localparam int COMP_W   = 8;
    localparam int WIDE_W   = 10;
    localparam int WORD_W   = 32;
    localparam int PART_W   = 20;
    localparam int SLOT_W   = 2;
    localparam int COUNT_W  = 13;
    localparam int ROWCNT_W = 12;
    localparam int PIX_W    = 12;
    localparam int STRIDE_W = 13;
    localparam int ROWS_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [SLOT_W-1:0] SLOT_LO  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_MID = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_HI  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WORDS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd2;

    typedef struct packed {
        logic              emit;
        logic              row_done;
        logic              frame_done;
        logic [WORD_W-1:0] word;
    } pack_item_t;

    typedef struct packed {
        logic out_free;
        logic pad_idle;
    } out_status_t;

endpackage

`default_nettype wire

@@ rtl/uyvy_to_v210_packer_core.sv @@
// ----------------------------------------------------------------------------
// uyvy_to_v210_packer_core
// Packs 8-bit UYVY components into v210 words with row padding and
// row/frame end marks.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_component[7:0]
//   m_      | out       | m_valid / m_ready    | m_packed_word[31:0], m_row_end,
//           |           |                      | m_frame_end
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[12:0]
//
// One component per cycle while s_ready is high; a data word shows in the
// cycle after the item that completes it. At a row end it is followed by up
// to MAX_PAD_WORDS padding words, one per cycle while m_ready is high, and
// s_ready stays low until the last one is loaded into the result register.
// Reset loads the default geometry and clears all counters. A stalled
// m_ready holds the result register and stops input through s_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module uyvy_to_v210_packer_core #(
    parameter int MAX_ROW_PIXELS = 2048,
    parameter int MAX_ROWS       = 4096,
    parameter int MAX_PAD_WORDS  = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [uvp_pkg::COMP_W-1:0]        s_component,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [uvp_pkg::WORD_W-1:0]             m_packed_word,
    output logic                                   m_row_end,
    output logic                                   m_frame_end,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [uvp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [uvp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PAD_W = $clog2(MAX_PAD_WORDS + 1);

    logic [uvp_pkg::PIX_W-1:0]    row_pixels_reg, row_pixels_next;
    logic [uvp_pkg::STRIDE_W-1:0] row_words_reg, row_words_next;
    logic [uvp_pkg::ROWS_W-1:0]   frame_rows_reg, frame_rows_next;

    uvp_pkg::pack_item_t  item;
    uvp_pkg::out_status_t status;
    logic [PAD_W-1:0]     pad;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = status.out_free && status.pad_idle;
    assign accept    = s_valid && s_ready;

    always_comb begin
        row_pixels_next = row_pixels_reg;
        row_words_next  = row_words_reg;
        frame_rows_next = frame_rows_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                uvp_pkg::REG_ROW_PIXELS: row_pixels_next = cfg_data[uvp_pkg::PIX_W-1:0];
                uvp_pkg::REG_ROW_WORDS:  row_words_next  = cfg_data;
                uvp_pkg::REG_FRAME_ROWS: frame_rows_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pixels_reg <= uvp_pkg::PIX_W'(1920);
            row_words_reg  <= uvp_pkg::STRIDE_W'(1280);
            frame_rows_reg <= uvp_pkg::ROWS_W'(1080);
        end else begin
            row_pixels_reg <= row_pixels_next;
            row_words_reg  <= row_words_next;
            frame_rows_reg <= frame_rows_next;
        end
    end

    uvp_pack #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .MAX_ROWS       (MAX_ROWS),
        .MAX_PAD_WORDS  (MAX_PAD_WORDS),
        .PAD_W          (PAD_W)
    ) u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .component  (s_component),
        .row_pixels (row_pixels_reg),
        .row_words  (row_words_reg),
        .frame_rows (frame_rows_reg),
        .item       (item),
        .pad        (pad)
    );

    uvp_out #(
        .MAX_PAD_WORDS (MAX_PAD_WORDS),
        .PAD_W         (PAD_W)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .item          (item),
        .pad           (pad),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

endmodule

`default_nettype wire

@@ rtl/uvp_pack.sv @@
// ----------------------------------------------------------------------------
// uvp_pack
// Row/frame counters and word assembly; packs up to three accepted
// components into each data word and computes the padding count at a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module uvp_pack #(
    parameter int MAX_ROW_PIXELS = 2048,
    parameter int MAX_ROWS       = 4096,
    parameter int MAX_PAD_WORDS  = 32,
    parameter int PAD_W          = $clog2(MAX_PAD_WORDS + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            accept,
    input  wire logic [uvp_pkg::COMP_W-1:0]      component,
    input  wire logic [uvp_pkg::PIX_W-1:0]       row_pixels,
    input  wire logic [uvp_pkg::STRIDE_W-1:0]    row_words,
    input  wire logic [uvp_pkg::ROWS_W-1:0]      frame_rows,
    output uvp_pkg::pack_item_t                  item,
    output logic [PAD_W-1:0]                     pad
);

    logic [uvp_pkg::SLOT_W-1:0]   group_slot_reg, group_slot_next;
    logic [uvp_pkg::PART_W-1:0]   partial_reg, partial_next;
    logic [uvp_pkg::COUNT_W-1:0]  comp_cnt_reg, comp_cnt_next;
    logic [uvp_pkg::COUNT_W-1:0]  word_cnt_reg, word_cnt_next;
    logic [uvp_pkg::ROWCNT_W-1:0] row_cnt_reg, row_cnt_next;

    logic [uvp_pkg::WIDE_W-1:0]   comp10;
    logic [uvp_pkg::PIX_W-1:0]    pix;
    logic [uvp_pkg::COUNT_W-1:0]  target;
    logic [uvp_pkg::ROWS_W-1:0]   rows;
    logic [uvp_pkg::ROWS_W-1:0]   rows_m1;
    logic [uvp_pkg::SLOT_W-1:0]   slot;
    logic [uvp_pkg::WORD_W-1:0]   placed;
    logic [uvp_pkg::WORD_W-1:0]   word;
    logic [uvp_pkg::COUNT_W-1:0]  cnt_inc;
    logic [uvp_pkg::COUNT_W-1:0]  wcnt_inc;
    logic [uvp_pkg::STRIDE_W-1:0] diff;
    logic                         row_done;
    logic                         frame_done;
    logic                         emit;

    assign comp10 = {component, 2'b00};

    always_comb begin
        if ({2'b00, row_pixels} > 14'(MAX_ROW_PIXELS)) begin
            pix = uvp_pkg::PIX_W'(MAX_ROW_PIXELS);
        end else begin
            pix = row_pixels;
        end
        if (frame_rows == '0) begin
            rows = uvp_pkg::ROWS_W'(1);
        end else if ({1'b0, frame_rows} > 14'(MAX_ROWS)) begin
            rows = uvp_pkg::ROWS_W'(MAX_ROWS);
        end else begin
            rows = frame_rows;
        end
    end

    assign target  = {pix, 1'b0};
    assign rows_m1 = rows - uvp_pkg::ROWS_W'(1);
    assign slot    = (group_slot_reg > uvp_pkg::SLOT_HI) ? uvp_pkg::SLOT_HI : group_slot_reg;

    always_comb begin
        case (slot)
            uvp_pkg::SLOT_LO:  placed = {22'd0, comp10};
            uvp_pkg::SLOT_MID: placed = {12'd0, comp10, 10'd0};
            default:           placed = {2'd0, comp10, 20'd0};
        endcase
    end

    assign word       = placed | {12'd0, partial_reg};
    assign cnt_inc    = comp_cnt_reg + uvp_pkg::COUNT_W'(1);
    assign wcnt_inc   = word_cnt_reg + uvp_pkg::COUNT_W'(1);
    assign row_done   = cnt_inc >= target;
    assign frame_done = row_done && ({1'b0, row_cnt_reg} >= rows_m1);
    assign emit       = (slot == uvp_pkg::SLOT_HI) || row_done;
    assign diff       = row_words - wcnt_inc;

    always_comb begin
        pad = '0;
        if (row_done && (wcnt_inc < row_words)) begin
            if (diff > uvp_pkg::STRIDE_W'(MAX_PAD_WORDS)) begin
                pad = PAD_W'(MAX_PAD_WORDS);
            end else begin
                pad = diff[PAD_W-1:0];
            end
        end
    end

    assign item.emit       = emit;
    assign item.row_done   = row_done;
    assign item.frame_done = frame_done;
    assign item.word       = word;

    always_comb begin
        group_slot_next = group_slot_reg;
        partial_next    = partial_reg;
        comp_cnt_next   = comp_cnt_reg;
        word_cnt_next   = word_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        if (accept) begin
            if (emit) begin
                group_slot_next = uvp_pkg::SLOT_LO;
                partial_next    = '0;
                word_cnt_next   = wcnt_inc;
            end else begin
                group_slot_next = slot + uvp_pkg::SLOT_W'(1);
                partial_next    = word[uvp_pkg::PART_W-1:0];
            end
            comp_cnt_next = cnt_inc;
            if (row_done) begin
                comp_cnt_next = '0;
                word_cnt_next = '0;
                row_cnt_next  = frame_done ? '0 : row_cnt_reg + uvp_pkg::ROWCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_slot_reg <= '0;
            partial_reg    <= '0;
            comp_cnt_reg   <= '0;
            word_cnt_reg   <= '0;
            row_cnt_reg    <= '0;
        end else begin
            group_slot_reg <= group_slot_next;
            partial_reg    <= partial_next;
            comp_cnt_reg   <= comp_cnt_next;
            word_cnt_reg   <= word_cnt_next;
            row_cnt_reg    <= row_cnt_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        group_slot_reg != 2'd3)
        else $error("group slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && row_done |=> comp_cnt_reg == '0 && word_cnt_reg == '0 &&
                               group_slot_reg == uvp_pkg::SLOT_LO)
        else $error("row end did not clear counters");

    assert property (@(posedge aclk) disable iff (!aresetn)
        group_slot_reg == uvp_pkg::SLOT_LO |-> partial_reg == '0)
        else $error("partial word not empty at group start");

endmodule

`default_nettype wire

@@ rtl/uvp_out.sv @@
// ----------------------------------------------------------------------------
// uvp_out
// Result register and padding sequencer; emits the data word, then the
// zero padding words of a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module uvp_out #(
    parameter int MAX_PAD_WORDS = 32,
    parameter int PAD_W         = $clog2(MAX_PAD_WORDS + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire uvp_pkg::pack_item_t          item,
    input  wire logic [PAD_W-1:0]             pad,
    output uvp_pkg::out_status_t              status,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [uvp_pkg::WORD_W-1:0]        m_packed_word,
    output logic                              m_row_end,
    output logic                              m_frame_end
);

    logic                      valid_reg, valid_next;
    logic [uvp_pkg::WORD_W-1:0] word_reg, word_next;
    logic                      row_end_reg, row_end_next;
    logic                      frame_end_reg, frame_end_next;
    logic [PAD_W-1:0]          pad_left_reg, pad_left_next;
    logic                      frame_pend_reg, frame_pend_next;
    logic                      out_free;
    logic                      last_pad;

    assign out_free = !valid_reg || m_ready;
    assign last_pad = pad_left_reg == PAD_W'(1);

    assign status.out_free = out_free;
    assign status.pad_idle = pad_left_reg == '0;

    always_comb begin
        valid_next      = valid_reg;
        word_next       = word_reg;
        row_end_next    = row_end_reg;
        frame_end_next  = frame_end_reg;
        pad_left_next   = pad_left_reg;
        frame_pend_next = frame_pend_reg;
        if (out_free) begin
            valid_next = 1'b0;
            if (pad_left_reg != '0) begin
                valid_next     = 1'b1;
                word_next      = '0;
                row_end_next   = last_pad;
                frame_end_next = last_pad && frame_pend_reg;
                pad_left_next  = pad_left_reg - PAD_W'(1);
            end else if (load && item.emit) begin
                valid_next      = 1'b1;
                word_next       = item.word;
                row_end_next    = item.row_done && (pad == '0);
                frame_end_next  = item.frame_done && (pad == '0);
                pad_left_next   = pad;
                frame_pend_next = item.frame_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            pad_left_reg   <= '0;
            frame_pend_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            pad_left_reg   <= pad_left_next;
            frame_pend_reg <= frame_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        row_end_reg   <= row_end_next;
        frame_end_reg <= frame_end_next;
    end

    assign m_valid       = valid_reg;
    assign m_packed_word = word_reg;
    assign m_row_end     = row_end_reg;
    assign m_frame_end   = frame_end_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && frame_end_reg |-> row_end_reg)
        else $error("frame end without row end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pad_left_reg != '0 |-> !load)
        else $error("item taken while padding pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pad_left_reg <= PAD_W'(MAX_PAD_WORDS))
        else $error("padding count above cap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load && item.emit && pad != '0 |=> pad_left_reg == $past(pad) && !row_end_reg)
        else $error("padding not started after data word");

endmodule

`default_nettype wire
